@@ rtl/tkd_pkg.sv @@
`default_nettype none

package tkd_pkg;

	localparam int LIST_DEPTH_DEF = 64;

	localparam int TIME_W   = 20;
	localparam int RECORD_W = 24;
	localparam int INDEX_W  = 2;

	// input item modes
	localparam logic [1:0] MODE_EVENT  = 2'd0;
	localparam logic [1:0] MODE_REPORT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_PERIOD_START = 2'd0;
	localparam logic [INDEX_W-1:0] REG_PERIOD_END   = 2'd1;
	localparam logic [INDEX_W-1:0] REG_FILTER_ON    = 2'd2;

	typedef struct packed {
		logic [1:0]          mode;
		logic [TIME_W-1:0]   sched_start;
		logic [TIME_W-1:0]   sched_end;
		logic [TIME_W-1:0]   sched_duration;
		logic [TIME_W-1:0]   actual_start;
		logic [TIME_W-1:0]   actual_end;
		logic [TIME_W-1:0]   actual_duration;
		logic [RECORD_W-1:0] record_id;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0]   rank_diff;
		logic [RECORD_W-1:0] rank_record;
		logic                list_empty;
		logic                last_entry;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0]   diff;
		logic [RECORD_W-1:0] rec;
	} entry_t;

	typedef enum logic [3:0] {
		CELL_HOLD   = 4'b0001,
		CELL_INSERT = 4'b0010,
		CELL_ROTATE = 4'b0100,
		CELL_CLEAR  = 4'b1000
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ins;
	} cell_cmd_t;

	typedef struct packed {
		logic busy;
		logic rotate;
	} rpt_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/tkd_cell.sv @@
`default_nettype none

module tkd_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tkd_pkg::cell_cmd_t cmd,
	input  wire logic              left_gt,
	input  wire tkd_pkg::entry_t   left,
	input  wire tkd_pkg::entry_t   right,
	output logic                   gt,
	output tkd_pkg::entry_t        ent
);

	tkd_pkg::entry_t ent_q;

	// new difference outranks this entry; equal entries keep their place
	assign gt  = cmd.ins.diff > ent_q.diff;
	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			unique case (cmd.op)
				tkd_pkg::CELL_INSERT: begin
					if (left_gt) begin
						ent_q <= left;
					end else if (gt) begin
						ent_q <= cmd.ins;
					end
				end
				tkd_pkg::CELL_ROTATE: ent_q <= right;
				tkd_pkg::CELL_CLEAR:  ent_q <= '0;
				tkd_pkg::CELL_HOLD:   ent_q <= ent_q;
				default:              ent_q <= ent_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/tkd_report.sv @@
`default_nettype none

module tkd_report #(
	parameter int LIST_DEPTH = tkd_pkg::LIST_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tkd_pkg::entry_t  head,
	input  wire tkd_pkg::entry_t  next,
	output tkd_pkg::rpt_ctrl_t    ctl,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output tkd_pkg::result_t      result
);

	localparam int CW = $clog2(LIST_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_REPORT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;
	tkd_pkg::result_t out_q;
	logic             slot_free;
	logic             step;
	logic             emit;
	logic             last_rot;

	assign slot_free = !out_valid_q || result_ready;
	assign step      = (state_q == ST_REPORT) && slot_free;
	assign last_rot  = cnt_q == CW'(LIST_DEPTH - 1);
	// first rotation always emits (the empty marker if the head is vacant)
	assign emit      = step && ((cnt_q == '0) || (head.diff != '0));

	assign ctl.busy   = state_q == ST_REPORT;
	assign ctl.rotate = step;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (step) begin
						cnt_q <= cnt_q + CW'(1);
						if (last_rot) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (head.diff == '0) begin
				out_q.rank_diff   <= '0;
				out_q.rank_record <= '0;
				out_q.list_empty  <= 1'b1;
				out_q.last_entry  <= 1'b1;
			end else begin
				out_q.rank_diff   <= head.diff;
				out_q.rank_record <= head.rec;
				out_q.list_empty  <= 1'b0;
				out_q.last_entry  <= last_rot || (next.diff == '0);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/top_k_difference_tracker.sv @@
`default_nettype none

// Ranked list of the LIST_DEPTH largest absolute differences between scheduled
// and actual trip durations, each kept with its record index. The list lives in
// a row of identical cells, largest at cell 0. An event request is checked
// (both intervals non-empty, optional window overlap), its difference worked
// out in one register stage, and in the next cycle every cell compares it with
// its own entry: the cells beyond the insertion point take their left
// neighbour's entry, the insertion cell takes the new one, the tail entry drops
// off. Events are taken one per cycle while no report is in progress and are
// in the list from the clock edge after the one that accepts them. A report
// request rotates the whole row towards cell 0 once, one cell per cycle while
// the result output is free, emitting each occupied head entry; it holds the
// input off from the cycle the request waits in the first stage until the last
// rotation, and the rotation leaves the list as it was. A report on an empty
// list yields a single result marked empty. A clear request empties the row.
// Configuration writes are always taken; write them only while idle.
module top_k_difference_tracker #(
	parameter int LIST_DEPTH = tkd_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire tkd_pkg::item_t                item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output tkd_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tkd_pkg::INDEX_W-1:0]   cfg_index,
	input  wire logic [tkd_pkg::TIME_W-1:0]    cfg_data
);

	// pending operation held in the first stage
	typedef enum logic [3:0] {
		PEND_NONE   = 4'b0001,
		PEND_INSERT = 4'b0010,
		PEND_REPORT = 4'b0100,
		PEND_CLEAR  = 4'b1000
	} pend_t;

	logic [tkd_pkg::TIME_W-1:0] period_start_q;
	logic [tkd_pkg::TIME_W-1:0] period_end_q;
	logic                       filter_on_q;

	pend_t                      pend_s1;
	tkd_pkg::entry_t            ins_s1;
	pend_t                      pend_d;
	logic                       accept;
	logic                       intervals_ok;
	logic                       sched_ov;
	logic                       actual_ov;
	logic                       window_ok;
	logic [tkd_pkg::TIME_W-1:0] abs_diff;

	tkd_pkg::cell_cmd_t         cmd;
	tkd_pkg::rpt_ctrl_t         ctl;
	tkd_pkg::entry_t            ent [LIST_DEPTH];
	logic                       gt  [LIST_DEPTH];

	// configuration registers: always ready, writes beyond the list ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_start_q <= '0;
			period_end_q   <= '1;
			filter_on_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tkd_pkg::REG_PERIOD_START: period_start_q <= cfg_data;
				tkd_pkg::REG_PERIOD_END:   period_end_q   <= cfg_data;
				tkd_pkg::REG_FILTER_ON:    filter_on_q    <= cfg_data[0];
				default:                   ;
			endcase
		end
	end

	// Hold off new requests for the whole of a report, including the cycle
	// in which it waits in the first stage.
	assign item_ready = !ctl.busy && (pend_s1 != PEND_REPORT);
	assign accept     = item_valid && item_ready;

	// Event screening: drop reversed or empty intervals, then apply the window.
	assign intervals_ok = (item.sched_start < item.sched_end)
	                   && (item.actual_start < item.actual_end);
	assign sched_ov  = (item.sched_start <= period_end_q)
	                && (item.sched_end >= period_start_q);
	assign actual_ov = (item.actual_start <= period_end_q)
	                && (item.actual_end >= period_start_q);
	assign window_ok = !filter_on_q || sched_ov || actual_ov;
	assign abs_diff  = (item.sched_duration >= item.actual_duration)
	                 ? (item.sched_duration - item.actual_duration)
	                 : (item.actual_duration - item.sched_duration);

	always_comb begin
		pend_d = PEND_NONE;
		if (accept) begin
			unique case (item.mode)
				tkd_pkg::MODE_EVENT: begin
					// a zero difference is never stored
					if (intervals_ok && window_ok && (abs_diff != '0)) begin
						pend_d = PEND_INSERT;
					end
				end
				tkd_pkg::MODE_REPORT: pend_d = PEND_REPORT;
				tkd_pkg::MODE_CLEAR:  pend_d = PEND_CLEAR;
				default:              pend_d = PEND_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= PEND_NONE;
		end else begin
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1.diff <= abs_diff;
			ins_s1.rec  <= item.record_id;
		end
	end

	// Broadcast command to the row: insert or clear from the first stage,
	// rotate while the report sequencer advances.
	always_comb begin
		cmd.ins = ins_s1;
		unique case (pend_s1)
			PEND_INSERT: cmd.op = tkd_pkg::CELL_INSERT;
			PEND_CLEAR:  cmd.op = tkd_pkg::CELL_CLEAR;
			default:     cmd.op = ctl.rotate ? tkd_pkg::CELL_ROTATE : tkd_pkg::CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		tkd_pkg::entry_t left_ent;
		tkd_pkg::entry_t right_ent;
		logic            left_gt;

		if (i == 0) begin : g_head
			// nothing ranks above the head
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_body
			assign left_ent = ent[i-1];
			assign left_gt  = gt[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_tail
			// close the ring so a report restores the list
			assign right_ent = ent[0];
		end else begin : g_mid
			assign right_ent = ent[i+1];
		end

		tkd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left_gt (left_gt),
			.left    (left_ent),
			.right   (right_ent),
			.gt      (gt[i]),
			.ent     (ent[i])
		);
	end

	tkd_report #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (pend_s1 == PEND_REPORT),
		.head         (ent[0]),
		.next         (ent[1]),
		.ctl          (ctl),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
